@@ src/idtmh_pkg.sv @@
// Shared types, codes and command encoding for the idle timeout heap.
package idtmh_pkg;
    localparam logic [1:0] OP_REGISTER   = 2'd0;
    localparam logic [1:0] OP_UNREGISTER = 2'd1;
    localparam logic [1:0] OP_TOUCH      = 2'd2;
    localparam logic [1:0] OP_SWEEP      = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;
    localparam logic [1:0] ST_DUP    = 2'd3;

    localparam logic [3:0] C_NOP      = 4'd0;
    localparam logic [3:0] C_LOAD     = 4'd1;
    localparam logic [3:0] C_REG_INS  = 4'd2;
    localparam logic [3:0] C_SP_RD    = 4'd3;
    localparam logic [3:0] C_TOUCH_LD = 4'd4;
    localparam logic [3:0] C_UNREG_LD = 4'd5;
    localparam logic [3:0] C_MV_LD    = 4'd6;
    localparam logic [3:0] C_ROOT_RD  = 4'd7;
    localparam logic [3:0] C_ROOT_RM  = 4'd8;
    localparam logic [3:0] C_SU_RD    = 4'd9;
    localparam logic [3:0] C_SU_MV    = 4'd10;
    localparam logic [3:0] C_SD_RD    = 4'd11;
    localparam logic [3:0] C_SD_MV    = 4'd12;
    localparam logic [3:0] C_PLACE    = 4'd13;

    localparam logic [1:0] EM_STATUS = 2'd0;
    localparam logic [1:0] EM_PEND   = 2'd1;
    localparam logic [1:0] EM_NONE   = 2'd2;

    typedef struct packed {
        logic [3:0] code;
        logic       emit;
        logic [1:0] emit_sel;
        logic [1:0] status;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       present;
        logic       full;
        logic       pos_zero;
        logic       pos_lt_cnt;
        logic       moved;
        logic       lt_a;
        logic       kid_in;
        logic       sd_stop;
        logic       expire;
        logic       pend;
        logic       out_free;
    } t_stat;
endpackage

@@ src/idtmh_ctrl.sv @@
// Sequencer for request decode, sift steps, sweep and result issue.
module idtmh_ctrl import idtmh_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_idle
);
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DECODE    = 4'd1;
    localparam logic [3:0] S_POS_LD    = 4'd2;
    localparam logic [3:0] S_UNREG_CHK = 4'd3;
    localparam logic [3:0] S_ROOT_ISS  = 4'd4;
    localparam logic [3:0] S_ROOT_CHK  = 4'd5;
    localparam logic [3:0] S_RM_CHK    = 4'd6;
    localparam logic [3:0] S_SU_RD     = 4'd7;
    localparam logic [3:0] S_SU_CMP    = 4'd8;
    localparam logic [3:0] S_SD_RD     = 4'd9;
    localparam logic [3:0] S_SD_CMP    = 4'd10;
    localparam logic [3:0] S_PLACE     = 4'd11;
    localparam logic [3:0] S_EMIT_ST   = 4'd12;
    localparam logic [3:0] S_EMIT_NONE = 4'd13;

    logic [3:0] r_state, n_state;
    logic [1:0] r_status, n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    assign o_idle = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.code = C_LOAD;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.op)
                    OP_REGISTER: begin
                        if (i_stat.present) begin
                            n_status = ST_DUP;
                            n_state  = S_EMIT_ST;
                        end else if (i_stat.full) begin
                            n_status = ST_FULL;
                            n_state  = S_EMIT_ST;
                        end else begin
                            o_cmd.code = C_REG_INS;
                            n_state    = S_SU_RD;
                        end
                    end
                    OP_UNREGISTER, OP_TOUCH: begin
                        if (!i_stat.present) begin
                            n_status = ST_ABSENT;
                            n_state  = S_EMIT_ST;
                        end else begin
                            o_cmd.code = C_SP_RD;
                            n_state    = S_POS_LD;
                        end
                    end
                    default: n_state = S_ROOT_ISS;
                endcase
            end
            S_POS_LD: begin
                if (i_stat.op == OP_TOUCH) begin
                    o_cmd.code = C_TOUCH_LD;
                    n_state    = S_SU_RD;
                end else begin
                    o_cmd.code = C_UNREG_LD;
                    n_state    = S_UNREG_CHK;
                end
            end
            S_UNREG_CHK: begin
                if (i_stat.pos_lt_cnt) begin
                    o_cmd.code = C_MV_LD;
                    n_state    = S_SU_RD;
                end else begin
                    n_status = ST_OK;
                    n_state  = S_EMIT_ST;
                end
            end
            S_ROOT_ISS: begin
                o_cmd.code = C_ROOT_RD;
                n_state    = S_ROOT_CHK;
            end
            S_ROOT_CHK: begin
                if (i_stat.pend) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.emit_sel = EM_PEND;
                        o_cmd.last     = !i_stat.expire;
                        if (i_stat.expire) begin
                            o_cmd.code = C_ROOT_RM;
                            n_state    = S_RM_CHK;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end else if (i_stat.expire) begin
                    o_cmd.code = C_ROOT_RM;
                    n_state    = S_RM_CHK;
                end else begin
                    n_state = S_EMIT_NONE;
                end
            end
            S_RM_CHK: begin
                if (i_stat.pos_lt_cnt) begin
                    o_cmd.code = C_MV_LD;
                    n_state    = S_SU_RD;
                end else begin
                    n_state = S_ROOT_ISS;
                end
            end
            S_SU_RD: begin
                if (i_stat.pos_zero) begin
                    n_state = i_stat.moved ? S_PLACE : S_SD_RD;
                end else begin
                    o_cmd.code = C_SU_RD;
                    n_state    = S_SU_CMP;
                end
            end
            S_SU_CMP: begin
                if (i_stat.lt_a) begin
                    o_cmd.code = C_SU_MV;
                    n_state    = S_SU_RD;
                end else begin
                    n_state = i_stat.moved ? S_PLACE : S_SD_RD;
                end
            end
            S_SD_RD: begin
                if (i_stat.kid_in) begin
                    o_cmd.code = C_SD_RD;
                    n_state    = S_SD_CMP;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_SD_CMP: begin
                if (!i_stat.sd_stop) begin
                    o_cmd.code = C_SD_MV;
                    n_state    = S_SD_RD;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                o_cmd.code = C_PLACE;
                n_status   = ST_OK;
                n_state    = (i_stat.op == OP_SWEEP) ? S_ROOT_ISS : S_EMIT_ST;
            end
            S_EMIT_ST: begin
                if (i_stat.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EM_STATUS;
                    o_cmd.status   = r_status;
                    o_cmd.last     = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_EMIT_NONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EM_NONE;
                    o_cmd.last     = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

@@ src/idtmh_dp.sv @@
// Heap memories, slot map, sift registers and result register.
module idtmh_dp import idtmh_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [1:0]  i_operation,
    input  logic [5:0]  i_conn_slot,
    input  logic [31:0] i_now_time,
    input  logic [15:0] i_timeout,
    input  logic        i_out_stall,
    output t_stat       o_stat,
    output logic        o_out_valid,
    output logic [5:0]  o_expired_slot,
    output logic        o_expired_valid,
    output logic [1:0]  o_status,
    output logic        o_last
);
    logic [5:0]  m_hs [CAPACITY];
    logic [31:0] m_ht [CAPACITY];
    logic [5:0]  m_sp [64];

    logic [1:0]  r_op;
    logic [5:0]  r_slot, r_pos, r_s, r_rda, r_pend_slot;
    logic [31:0] r_now, r_t;
    logic [6:0]  r_count;
    logic [63:0] r_present;
    logic        r_moved, r_pend;
    logic [5:0]  r_hsa, r_hsb, r_spq;
    logic [31:0] r_hta, r_htb;
    logic        r_ov, r_oev, r_olast;
    logic [5:0]  r_oslot;
    logic [1:0]  r_ost;

    logic [6:0]  kid7, right7;
    logic [5:0]  par, addr_a, w_pos, w_slot, kid_pos, kid_slot;
    logic [31:0] w_time, kid_time;
    logic        rd_a, rd_b, wr, right_ok, out_free;
    logic [32:0] due;

    assign kid7     = {r_pos, 1'b1};
    assign right7   = kid7 + 7'd1;
    assign par      = (r_pos - 6'd1) >> 1;
    assign right_ok = (right7 < r_count) && (r_htb < r_hta);
    assign kid_pos  = right_ok ? right7[5:0] : kid7[5:0];
    assign kid_slot = right_ok ? r_hsb : r_hsa;
    assign kid_time = right_ok ? r_htb : r_hta;
    assign due      = {1'b0, r_hta} + {17'd0, i_timeout};
    assign out_free = !r_ov || !i_out_stall;

    always_comb begin
        rd_a   = 1'b0;
        rd_b   = 1'b0;
        addr_a = par;
        unique case (i_cmd.code)
            C_ROOT_RD: begin
                rd_a   = 1'b1;
                addr_a = '0;
            end
            C_ROOT_RM, C_UNREG_LD: begin
                rd_a   = 1'b1;
                addr_a = 6'(r_count - 7'd1);
            end
            C_SU_RD: rd_a = 1'b1;
            C_SD_RD: begin
                rd_a   = 1'b1;
                rd_b   = 1'b1;
                addr_a = kid7[5:0];
            end
            default: ;
        endcase
    end

    always_comb begin
        wr     = 1'b1;
        w_pos  = r_pos;
        w_slot = r_s;
        w_time = r_t;
        unique case (i_cmd.code)
            C_SU_MV: begin
                w_slot = r_hsa;
                w_time = r_hta;
            end
            C_SD_MV: begin
                w_slot = kid_slot;
                w_time = kid_time;
            end
            C_PLACE: ;
            default: wr = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            m_hs[w_pos]  <= w_slot;
            m_ht[w_pos]  <= w_time;
            m_sp[w_slot] <= w_pos;
        end
        if (rd_a) begin
            r_hsa <= m_hs[addr_a];
            r_hta <= m_ht[addr_a];
            r_rda <= addr_a;
        end
        if (rd_b) begin
            r_hsb <= m_hs[right7[5:0]];
            r_htb <= m_ht[right7[5:0]];
        end
        if (i_cmd.code == C_SP_RD) begin
            r_spq <= m_sp[r_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_present <= '0;
            r_pend    <= 1'b0;
            r_moved   <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_ov <= 1'b1;
                unique case (i_cmd.emit_sel)
                    EM_PEND: begin
                        r_oslot <= r_pend_slot;
                        r_oev   <= 1'b1;
                        r_ost   <= ST_OK;
                    end
                    EM_NONE: begin
                        r_oslot <= '0;
                        r_oev   <= 1'b0;
                        r_ost   <= ST_OK;
                    end
                    default: begin
                        r_oslot <= r_slot;
                        r_oev   <= 1'b0;
                        r_ost   <= i_cmd.status;
                    end
                endcase
                r_olast <= i_cmd.last;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            unique case (i_cmd.code)
                C_LOAD: begin
                    r_op   <= i_operation;
                    r_slot <= i_conn_slot;
                    r_now  <= i_now_time;
                    r_pend <= 1'b0;
                end
                C_REG_INS: begin
                    r_present[r_slot] <= 1'b1;
                    r_pos   <= r_count[5:0];
                    r_s     <= r_slot;
                    r_t     <= r_now;
                    r_count <= r_count + 7'd1;
                    r_moved <= 1'b0;
                end
                C_TOUCH_LD: begin
                    r_pos   <= r_spq;
                    r_s     <= r_slot;
                    r_t     <= r_now;
                    r_moved <= 1'b0;
                end
                C_UNREG_LD: begin
                    r_present[r_slot] <= 1'b0;
                    r_pos   <= r_spq;
                    r_count <= r_count - 7'd1;
                    r_moved <= 1'b0;
                end
                C_ROOT_RM: begin
                    r_present[r_hsa] <= 1'b0;
                    r_pend_slot <= r_hsa;
                    r_pend      <= 1'b1;
                    r_pos       <= '0;
                    r_count     <= r_count - 7'd1;
                    r_moved     <= 1'b0;
                end
                C_MV_LD: begin
                    r_s <= r_hsa;
                    r_t <= r_hta;
                end
                C_SU_MV: begin
                    r_pos   <= r_rda;
                    r_moved <= 1'b1;
                end
                C_SD_MV: r_pos <= kid_pos;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_stat.op         = r_op;
        o_stat.present    = r_present[r_slot];
        o_stat.full       = r_count >= 7'(CAPACITY);
        o_stat.pos_zero   = (r_pos == '0);
        o_stat.pos_lt_cnt = {1'b0, r_pos} < r_count;
        o_stat.moved      = r_moved;
        o_stat.lt_a       = r_t < r_hta;
        o_stat.kid_in     = kid7 < r_count;
        o_stat.sd_stop    = r_t < kid_time;
        o_stat.expire     = (r_count != '0) && ({1'b0, r_now} >= due);
        o_stat.pend       = r_pend;
        o_stat.out_free   = out_free;
    end

    assign o_out_valid     = r_ov;
    assign o_expired_slot  = r_oslot;
    assign o_expired_valid = r_oev;
    assign o_status        = r_ost;
    assign o_last          = r_olast;
endmodule

@@ src/idle_timeout_min_heap.sv @@
// Top level: idle timeout min-heap timer queue with its APB register port.
// One request is worked at a time: o_in_stall is high from acceptance until the
// controller is back in idle. Each heap level that an entry moves needs one
// registered heap memory read and a compare; unregistering the entry in the last
// heap position needs no sift. A sweep removes expired root slots one at a time,
// each with a sift down, and gives a result with no slot if nothing expired. Each
// result waits in one output register, and a stalled result holds the controller.
// Register 0 at byte address 0 holds idle_timeout (16 bits, reset 60).
module idle_timeout_min_heap import idtmh_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [5:0]  i_conn_slot,
    input  logic [31:0] i_now_time,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [5:0]  o_expired_slot,
    output logic        o_expired_valid,
    output logic [1:0]  o_status,
    output logic        o_last
);
    logic [15:0] r_timeout;
    t_cmd        cmd;
    t_stat       stat;
    logic        idle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= 16'd60;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_timeout <= pwdata[15:0];
        end
    end

    assign pready     = 1'b1;
    assign prdata     = paddr[2] ? 32'd0 : {16'd0, r_timeout};
    assign o_in_stall = !idle;

    idtmh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_idle     (idle)
    );

    idtmh_dp #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_operation     (i_operation),
        .i_conn_slot     (i_conn_slot),
        .i_now_time      (i_now_time),
        .i_timeout       (r_timeout),
        .i_out_stall     (i_out_stall),
        .o_stat          (stat),
        .o_out_valid     (o_out_valid),
        .o_expired_slot  (o_expired_slot),
        .o_expired_valid (o_expired_valid),
        .o_status        (o_status),
        .o_last          (o_last)
    );
endmodule

@@ src/idtmh_chk.sv @@
// Port-level checker for the idle timeout heap, bound to the top level.
module idtmh_chk import idtmh_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [5:0] o_expired_slot,
    input logic       o_expired_valid,
    input logic [1:0] o_status,
    input logic       o_last
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_expired_slot)
            && $stable(o_last))
        else $error("result dropped or changed while stalled");

    a_exp_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_expired_valid |-> o_status == ST_OK)
        else $error("expired result with error status");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_last && !o_expired_valid)
        else $error("error result not final");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");
endmodule

bind idle_timeout_min_heap idtmh_chk u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_expired_slot  (o_expired_slot),
    .o_expired_valid (o_expired_valid),
    .o_status        (o_status),
    .o_last          (o_last)
);
